>>> hw/rtl/ectf_pkg.sv
`default_nettype none

package ectf_pkg;

   // command codes of an input item
   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_CAPTURE = 2'd1,
      CMD_POP     = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // a capture below half scale with an overflow pending belongs to the next high word
   localparam logic [15:0] HALF_COUNT = 16'h8000;

   // input item
   typedef struct packed {
      cmd_type     command;
      logic [15:0] captured_count;
      logic        overflow_pending;
   } req_type;

   // result item
   typedef struct packed {
      logic        pop_valid;
      logic [31:0] event_timestamp;
      logic        event_rising;
      logic        events_available;
      logic [15:0] dropped_total;
   } rsp_type;

   // one stored event
   typedef struct packed {
      logic [31:0] stamp;
      logic        rising;
   } entry_type;

   // registered status of one processed item, from control to the result mux
   typedef struct packed {
      logic        valid;
      logic        pop_valid;
      logic        available;
      logic [15:0] dropped;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ectf_store.sv
`default_nettype none

module ectf_store #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
   input  wire ectf_pkg::entry_type           wr_data,
   input  wire logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
   output ectf_pkg::entry_type                rd_data
);

   ectf_pkg::entry_type mem [FIFO_DEPTH];
   ectf_pkg::entry_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ectf_ctrl.sv
`default_nettype none

module ectf_ctrl #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire ectf_pkg::req_type             in_req,
   output logic                               wr_en,
   output logic [$clog2(FIFO_DEPTH)-1:0]      wr_addr,
   output ectf_pkg::entry_type                wr_data,
   output logic [$clog2(FIFO_DEPTH)-1:0]      rd_addr,
   output ectf_pkg::status_type               status
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

   logic                 item_valid_ff;
   ectf_pkg::req_type    item_ff;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [15:0]          high_ff, high_in;
   logic [15:0]          lost_ff, lost_in;
   logic                 sense_ff, sense_in;
   ectf_pkg::status_type status_ff, status_in;

   logic [PTR_W-1:0]     wr_next;
   logic [PTR_W-1:0]     rd_next;
   logic                 fifo_full;
   logic                 fifo_empty;
   logic [15:0]          high_sel;
   logic                 pop_hit;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= in_valid;
      end
      if (in_valid) begin
         item_ff <= in_req;
      end
   end

   // ring pointer arithmetic, modulo depth
   assign wr_next    = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next    = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign fifo_full  = (wr_next == rd_ptr_ff);
   assign fifo_empty = (rd_ptr_ff == wr_ptr_ff);

   // timestamp extension
   assign high_sel = high_ff + 16'((item_ff.overflow_pending &&
                                    (item_ff.captured_count < ectf_pkg::HALF_COUNT)) ? 1 : 0);

   assign wr_addr      = wr_ptr_ff;
   assign wr_data      = '{stamp: {high_sel, item_ff.captured_count}, rising: sense_ff};
   assign rd_addr      = rd_ptr_ff;

   // item decode and state update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      high_in   = high_ff;
      lost_in   = lost_ff;
      sense_in  = sense_ff;
      wr_en     = 1'b0;
      pop_hit   = 1'b0;
      if (item_valid_ff) begin
         unique case (item_ff.command)
            ectf_pkg::CMD_TICK: begin
               high_in = high_ff + 16'd1;
            end
            ectf_pkg::CMD_CAPTURE: begin
               if (!fifo_full) begin
                  wr_en     = 1'b1;
                  wr_ptr_in = wr_next;
               end else begin
                  lost_in = lost_ff + 16'd1;
               end
               sense_in = ~sense_ff;
            end
            ectf_pkg::CMD_POP: begin
               if (!fifo_empty) begin
                  pop_hit   = 1'b1;
                  rd_ptr_in = rd_next;
               end
            end
            default: begin
            end
         endcase
      end
      status_in.valid     = item_valid_ff;
      status_in.pop_valid = pop_hit;
      status_in.available = (rd_ptr_in != wr_ptr_in);
      status_in.dropped   = lost_in;
   end

   // state and result status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         high_ff   <= '0;
         lost_ff   <= '0;
         sense_ff  <= 1'b1;
         status_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         high_ff   <= high_in;
         lost_ff   <= lost_in;
         sense_ff  <= sense_in;
         status_ff <= status_in;
      end
   end

   assign status = status_ff;

`ifndef SYNTHESIS
   // a write never fills the last free slot
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_next != rd_ptr_ff))
      else $error("capture written into a full fifo");

   // only a capture changes the drop counter
   a_lost_only_capture: assert property (@(posedge clock) disable iff (reset)
      !(item_valid_ff && (item_ff.command == ectf_pkg::CMD_CAPTURE)) |=>
         (lost_ff == $past(lost_ff)))
      else $error("drop counter moved without a capture");

   // only a tick changes the high word
   a_high_only_tick: assert property (@(posedge clock) disable iff (reset)
      !(item_valid_ff && (item_ff.command == ectf_pkg::CMD_TICK)) |=>
         (high_ff == $past(high_ff)))
      else $error("high word moved without a tick");

   // a popped event comes with a result strobe
   a_pop_has_result: assert property (@(posedge clock) disable iff (reset)
      status_ff.pop_valid |-> status_ff.valid)
      else $error("pop reported outside a result");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/edge_timestamp_capture_fifo.sv
`default_nettype none

// Extends 16-bit timer captures to 32-bit timestamps and queues them with
// their edge polarity in a ring fifo of FIFO_DEPTH slots, of which
// FIFO_DEPTH - 1 hold events. One item is taken at every clock at which start
// is high; busy never rises. Every item gives exactly one result. The item
// is first held in the input register; at the next clock the pointer update,
// the result register and the registered read port of the event store all
// load. The result is then shown with rsp_valid for one cycle. The receiver
// cannot stall, so results must be taken as they come. The event store is
// not cleared at reset; only written slots are ever popped.
module edge_timestamp_capture_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ectf_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ectf_pkg::rsp_type      rsp_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic                 wr_en;
   logic [PTR_W-1:0]     wr_addr;
   ectf_pkg::entry_type  wr_data;
   logic [PTR_W-1:0]     rd_addr;
   ectf_pkg::entry_type  rd_data;
   ectf_pkg::status_type status;

   assign busy = 1'b0;

   // pointers, counters and item decode
   ectf_ctrl #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_req   (req_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .status   (status)
   );

   // event storage
   ectf_store #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result item, event fields zero unless a pop hit
   assign rsp_valid                 = status.valid;
   assign rsp_data.pop_valid        = status.pop_valid;
   assign rsp_data.event_timestamp  = status.pop_valid ? rd_data.stamp : 32'd0;
   assign rsp_data.event_rising     = status.pop_valid & rd_data.rising;
   assign rsp_data.events_available = status.available;
   assign rsp_data.dropped_total    = status.dropped;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH          = 16;
   localparam int STALL_LIMIT    = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 8;
   localparam ectf_pkg::rsp_type NO_RSP   = '0;
   // after reset, then one capture dropped on a full fifo
   localparam ectf_pkg::rsp_type ONE_DROP = '{1'b0, 32'h0, 1'b0, 1'b1, 16'd1};

   // one row of the directed table
   typedef struct packed {
      ectf_pkg::req_type req;
      logic              typed;
      ectf_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   ectf_pkg::req_type req_data;
   logic              rsp_valid;
   ectf_pkg::rsp_type rsp_data;

   // typed expectation for the item on the input ports
   logic              cur_typed;
   ectf_pkg::rsp_type cur_want;

   // predictor state
   ectf_pkg::entry_type model_store [DEPTH];
   int                  model_wr;
   int                  model_rd;
   logic [15:0]         model_high;
   logic [15:0]         model_lost;
   logic                model_rising;

   ectf_pkg::rsp_type predicted_rsp_q [$];
   int                mismatches;
   int                stall_cycles;

   dir_row_type dir_rows [0:24] = '{
      '{'{ectf_pkg::CMD_POP,     16'h0000, 1'b0}, 1'b1, NO_RSP},
      '{'{ectf_pkg::CMD_NONE,    16'hFFFF, 1'b1}, 1'b1, NO_RSP},
      '{'{ectf_pkg::CMD_TICK,    16'hFFFF, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h7FFF, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h8000, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hFFFF, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h0000, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_POP,     16'hFFFF, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_POP,     16'h5555, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h0001, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h0002, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hAAAA, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h5555, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h7FFE, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h8001, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h1234, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hFEDC, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h00FF, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hFF00, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h0F0F, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hF0F0, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'h3C3C, 1'b1}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_CAPTURE, 16'hC3C3, 1'b0}, 1'b1, ONE_DROP},
      '{'{ectf_pkg::CMD_POP,     16'h0000, 1'b0}, 1'b0, NO_RSP},
      '{'{ectf_pkg::CMD_TICK,    16'h0000, 1'b0}, 1'b0, NO_RSP}
   };

   edge_timestamp_capture_fifo #(
      .FIFO_DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // next result of the block for one item, advancing the predictor state
   function automatic ectf_pkg::rsp_type predict_capture_fifo(ectf_pkg::req_type r);
      ectf_pkg::rsp_type o;
      logic [15:0]       high;
      int                nxt;
      o = '0;
      case (r.command)
         ectf_pkg::CMD_TICK: begin
            model_high = model_high + 16'd1;
         end
         ectf_pkg::CMD_CAPTURE: begin
            high = model_high;
            // count below half scale with overflow pending belongs to the next word
            if (r.overflow_pending && r.captured_count < ectf_pkg::HALF_COUNT) begin
               high = high + 16'd1;
            end
            nxt = (model_wr + 1) % DEPTH;
            if (nxt != model_rd) begin
               model_store[model_wr] = '{stamp: {high, r.captured_count},
                                         rising: model_rising};
               model_wr = nxt;
            end else begin
               model_lost = model_lost + 16'd1;
            end
            model_rising = ~model_rising;
         end
         ectf_pkg::CMD_POP: begin
            if (model_rd != model_wr) begin
               o.pop_valid       = 1'b1;
               o.event_timestamp = model_store[model_rd].stamp;
               o.event_rising    = model_store[model_rd].rising;
               model_rd          = (model_rd + 1) % DEPTH;
            end
         end
         default: begin
         end
      endcase
      o.events_available = (model_rd != model_wr);
      o.dropped_total    = model_lost;
      return o;
   endfunction

   function automatic ectf_pkg::req_type mk_req(ectf_pkg::cmd_type c, logic [15:0] cnt,
                                                logic pend);
      ectf_pkg::req_type r;
      r.command          = c;
      r.captured_count   = cnt;
      r.overflow_pending = pend;
      return r;
   endfunction

   // random item; pct weights for capture and pop, rest split over tick and none
   function automatic ectf_pkg::req_type rand_item(int cap_pct, int pop_pct);
      int                roll;
      ectf_pkg::cmd_type c;
      logic [15:0]       cnt;
      roll = $urandom_range(0, 99);
      if (roll < cap_pct) begin
         c = ectf_pkg::CMD_CAPTURE;
      end else if (roll < cap_pct + pop_pct) begin
         c = ectf_pkg::CMD_POP;
      end else if ($urandom_range(0, 3) != 0) begin
         c = ectf_pkg::CMD_TICK;
      end else begin
         c = ectf_pkg::CMD_NONE;
      end
      // hit the half scale boundary now and then
      if ($urandom_range(0, 3) == 0) begin
         cnt = 16'($urandom_range(32'h7FF0, 32'h800F));
      end else begin
         cnt = 16'($urandom);
      end
      return mk_req(c, cnt, 1'($urandom));
   endfunction

   function automatic int pick_gap(bit idle_ok);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 13);
      end
      return 0;
   endfunction

   // drive one item from a falling edge until it is taken; returns at a falling edge
   task automatic send_item(ectf_pkg::req_type it, int gap, logic typed,
                            ectf_pkg::rsp_type want);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_data  <= it;
      cur_typed  = typed;
      cur_want   = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // random blocks that lean toward filling, draining, mixing or noise
   task automatic run_random(int n_items, bit idle_ok);
      int                sent;
      int                blk_len;
      int                mode;
      bit                blk_idle;
      ectf_pkg::req_type it;
      sent = 0;
      while (sent < n_items) begin
         blk_len  = $urandom_range(8, 30);
         mode     = $urandom_range(0, 3);
         blk_idle = idle_ok && ($urandom_range(0, 2) != 0);
         repeat (blk_len) begin
            case (mode)
               0:       it = rand_item(70, 15);
               1:       it = rand_item(15, 70);
               2:       it = rand_item(40, 40);
               default: it = mk_req(ectf_pkg::cmd_type'($urandom_range(0, 3)),
                                    16'($urandom), 1'($urandom));
            endcase
            send_item(it, pick_gap(blk_idle), 1'b0, NO_RSP);
            sent++;
         end
      end
   endtask

   // drain, then captures on both sides of half scale with and without pending carry
   task automatic run_carry();
      repeat (DEPTH) send_item(mk_req(ectf_pkg::CMD_POP, 16'h0, 1'b0), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_CAPTURE, 16'h1234, 1'b1), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_CAPTURE, 16'h9000, 1'b1), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_CAPTURE, 16'h7FFF, 1'b1), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_CAPTURE, 16'h8000, 1'b1), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_CAPTURE, 16'h8000, 1'b0), 0, 1'b0, NO_RSP);
      repeat (6) send_item(mk_req(ectf_pkg::CMD_POP, 16'h0, 1'b0), 0, 1'b0, NO_RSP);
      send_item(mk_req(ectf_pkg::CMD_TICK, 16'h0, 1'b0), 0, 1'b0, NO_RSP);
   endtask

   // check results and record taken items at every rising edge
   always @(posedge clock) begin : monitor
      ectf_pkg::rsp_type want;
      bit                active;
      if (!reset) begin
         active = 1'b0;
         if (rsp_valid) begin
            active = 1'b1;
            if (predicted_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("unexpected result: pv=%0d ts=%h r=%0d av=%0d dr=%h",
                           rsp_data.pop_valid, rsp_data.event_timestamp,
                           rsp_data.event_rising, rsp_data.events_available,
                           rsp_data.dropped_total);
               end
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_data.pop_valid !== want.pop_valid ||
                   rsp_data.event_timestamp !== want.event_timestamp ||
                   rsp_data.event_rising !== want.event_rising ||
                   rsp_data.events_available !== want.events_available ||
                   rsp_data.dropped_total !== want.dropped_total) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("mismatch: want pv=%0d ts=%h r=%0d av=%0d dr=%h",
                              want.pop_valid, want.event_timestamp, want.event_rising,
                              want.events_available, want.dropped_total);
                     $display("          got  pv=%0d ts=%h r=%0d av=%0d dr=%h",
                              rsp_data.pop_valid, rsp_data.event_timestamp,
                              rsp_data.event_rising, rsp_data.events_available,
                              rsp_data.dropped_total);
                  end
               end
            end
         end
         if (start && !busy) begin
            active = 1'b1;
            want   = predict_capture_fifo(req_data);
            predicted_rsp_q.push_back(cur_typed ? cur_want : want);
         end
         stall_cycles = active ? 0 : stall_cycles + 1;
      end
   end

   // watchdog on cycles with nothing taken
   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      cur_typed    = 1'b0;
      cur_want     = '0;
      mismatches   = 0;
      stall_cycles = 0;
      model_wr     = 0;
      model_rd     = 0;
      model_high   = '0;
      model_lost   = '0;
      model_rising = 1'b1;
      foreach (model_store[i]) model_store[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < 25; i++) begin
         send_item(dir_rows[i].req, pick_gap(1'b1), dir_rows[i].typed, dir_rows[i].want);
      end

      run_random(450, 1'b1);
      run_carry();
      // closing stretch without idling
      run_random(150, 1'b0);
      start <= 1'b0;

      // drain outstanding results
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += predicted_rsp_q.size();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> edge_timestamp_capture_fifo.f
hw/rtl/ectf_pkg.sv
hw/rtl/ectf_store.sv
hw/rtl/ectf_ctrl.sv
hw/rtl/edge_timestamp_capture_fifo.sv
sim/tb_top.sv
